// ===== design/bpa_pkg.sv =====
`default_nettype none

package bpa_pkg;

  // Pool geometry.
  localparam int PAGE_COUNT = 1024;
  localparam int PAGE_SHIFT = 12;

  localparam int ADDR_W = 32;
  localparam int WORD_W = 32;
  localparam int BIT_W  = 5;
  localparam int WORDS  = (PAGE_COUNT + WORD_W - 1) / WORD_W;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;

  // Page index arithmetic for the init range, wide enough for PAGE_COUNT itself.
  localparam int IW = $clog2(PAGE_COUNT + 1) + BIT_W + 1;

  // Init bound arithmetic needs carry room above 32 bits.
  localparam int AW = ADDR_W + 2;

  localparam logic [AW-1:0]     PG_MASK_W = AW'((64'd1 << PAGE_SHIFT) - 64'd1);
  localparam logic [ADDR_W-1:0] PG_MASK   = ADDR_W'((64'd1 << PAGE_SHIFT) - 64'd1);

  // Request kinds.
  localparam logic [1:0] ACT_ALLOC = 2'd0;
  localparam logic [1:0] ACT_FREE  = 2'd1;
  localparam logic [1:0] ACT_INIT  = 2'd2;
  localparam logic [1:0] ACT_QUERY = 2'd3;

  // Result status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_OOM   = 2'd1;
  localparam logic [1:0] STAT_RANGE = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
  localparam logic [1:0] CFG_FREE_START = 2'd1;
  localparam logic [1:0] CFG_FREE_END   = 2'd2;

  // Page index bounds of an init pass: pages below kclr are cleared, pages in
  // [set_lo, set_hi) are set afterwards. All are clipped to PAGE_COUNT.
  typedef struct packed {
    logic          done;
    logic [IW-1:0] kclr;
    logic [IW-1:0] set_lo;
    logic [IW-1:0] set_hi;
  } range_t;

  // Bits of word w whose page index lies below k.
  function automatic logic [WORD_W-1:0] lt_mask(input logic [IW-1:0] k,
                                                 input logic [WA_W-1:0] w);
    logic [IW-1:0] kw;
    logic [IW-1:0] ww;
    logic [WORD_W-1:0] m;
    kw = k >> BIT_W;
    ww = IW'(w);
    if (ww < kw) begin
      m = '1;
    end else if (ww == kw) begin
      m = (WORD_W'(1) << k[BIT_W-1:0]) - WORD_W'(1);
    end else begin
      m = '0;
    end
    return m;
  endfunction

endpackage

`default_nettype wire

// ===== design/bitmap_page_allocator.sv =====
`default_nettype none

// Channel   Direction  Handshake              Contents
// in        to block   in_valid / in_ready    action, address, page_index
// out       from block out_valid / out_ready  page_address, page_free, status
// cfg       to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One request at a time. Allocate reads words until one holds a free page, up
// to WORDS words (32 at the default size); init reads and rewrites every word
// once its bounds are ready; free and query read at most one word. The bitmap
// memory's single read port, walked one 32-bit word a cycle, sets the pace. After
// reset a clearing pass writes every word to zero, with in_ready low; configuration
// writes are always taken. A waiting result sits in the output register while the
// next request is accepted and worked on; that request then holds in its last
// state until the output register is free.

module bitmap_page_allocator import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [9:0]        page_index,

  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [ADDR_W-1:0]      page_address,
  output logic                   page_free,
  output logic [1:0]             status,

  input  wire logic              cfg_valid,
  output logic                   cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data
);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_ALLOC = 4'd2;
  localparam logic [3:0] S_FCHK  = 4'd3;
  localparam logic [3:0] S_RMW   = 4'd4;
  localparam logic [3:0] S_INIT  = 4'd5;
  localparam logic [3:0] S_ISCAN = 4'd6;
  localparam logic [3:0] S_FIN   = 4'd7;

  localparam logic [WA_W-1:0] LAST_WORD = WA_W'(WORDS - 1);

  logic [3:0] state;

  // Configuration registers.
  logic [ADDR_W-1:0] pool_base;
  logic [ADDR_W-1:0] free_start;
  logic [ADDR_W-1:0] free_end;

  // Bitmap memory: one bit per page, 1 means free. Reads are registered and return in the following cycle.
  logic [WORD_W-1:0] mem [0:WORDS-1];
  logic [WORD_W-1:0] mem_q;
  logic              rd_en;
  logic [WA_W-1:0]   rd_addr;
  logic              wr_en;
  logic [WA_W-1:0]   wr_addr;
  logic [WORD_W-1:0] wr_data;

  // Request context.
  logic [1:0]        op;
  logic [ADDR_W-1:0] addr_l;
  logic [WA_W-1:0]   wsel;
  logic [BIT_W-1:0]  bsel;
  logic [WA_W-1:0]   ptr;
  logic [WA_W-1:0]   chk;

  // Pending result.
  logic [ADDR_W-1:0] res_addr;
  logic              res_free;
  logic [1:0]        res_status;

  range_t            rng;
  logic              rng_start;

  logic              accept;
  logic [ADDR_W-1:0] q_ext;
  logic              q_ok;

  logic [ADDR_W-1:0] f_round;
  logic [ADDR_W-1:0] f_k;
  logic              f_ok;

  logic [WORD_W-1:0] lowest;
  logic [BIT_W-1:0]  low_bit;
  logic [WORD_W-1:0] alloc_word;
  logic [ADDR_W-1:0] alloc_idx;
  logic [ADDR_W-1:0] alloc_addr;
  logic [WORD_W-1:0] init_word;
  logic              out_free;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign rng_start = accept && (action == ACT_INIT);
  assign out_free  = !out_valid || out_ready;

  // Query index checked against the pool size.
  assign q_ext = ADDR_W'(page_index);
  assign q_ok  = q_ext < ADDR_W'(PAGE_COUNT);

  // Free address: round down, then page index relative to the pool.
  assign f_round = addr_l & ~PG_MASK;
  assign f_k     = (f_round - pool_base) >> PAGE_SHIFT;
  assign f_ok    = (f_round >= pool_base) && (f_k < ADDR_W'(PAGE_COUNT));

  // Lowest free page in the word under examination.
  always_comb begin
    lowest  = mem_q & (~mem_q + WORD_W'(1));
    low_bit = '0;
    for (int i = 0; i < WORD_W; i++) begin
      if (lowest[i]) begin
        low_bit = low_bit | BIT_W'(i);
      end
    end
  end

  assign alloc_word = mem_q & ~lowest;
  assign alloc_idx  = (ADDR_W'(chk) << BIT_W) | ADDR_W'(low_bit);
  assign alloc_addr = pool_base + (alloc_idx << PAGE_SHIFT);

  // Init rewrites one word: the kernel region is cleared first, then the free
  // range is set on top of it.
  assign init_word = (mem_q & ~lt_mask(rng.kclr, chk))
                   | (lt_mask(rng.set_hi, chk) & ~lt_mask(rng.set_lo, chk));

  bpa_range u_range (
    .clk        (clk),
    .rst        (rst),
    .start      (rng_start),
    .pool_base  (pool_base),
    .free_start (free_start),
    .free_end   (free_end),
    .rng        (rng)
  );

  // Memory port control. The scans write word chk while reading word chk+1,
  // and a free writes only after its read returns, so one entry is never read
  // and written in the same cycle.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = ptr;
    wr_en   = 1'b0;
    wr_addr = chk;
    wr_data = init_word;
    unique case (state)
      S_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = ptr;
        wr_data = '0;
      end
      S_IDLE: begin
        if (accept && (action == ACT_ALLOC)) begin
          rd_en   = 1'b1;
          rd_addr = '0;
        end else if (accept && (action == ACT_QUERY) && q_ok) begin
          rd_en   = 1'b1;
          rd_addr = q_ext[WA_W+BIT_W-1:BIT_W];
        end
      end
      S_ALLOC: begin
        rd_en   = 1'b1;
        wr_en   = (mem_q != '0);
        wr_data = alloc_word;
      end
      S_FCHK: begin
        rd_en   = f_ok;
        rd_addr = f_k[WA_W+BIT_W-1:BIT_W];
      end
      S_RMW: begin
        wr_en   = (op == ACT_FREE);
        wr_addr = wsel;
        wr_data = mem_q | (WORD_W'(1) << bsel);
      end
      S_INIT: begin
        rd_en   = rng.done;
        rd_addr = '0;
      end
      S_ISCAN: begin
        rd_en = 1'b1;
        wr_en = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Configuration writes; an index past the last register is dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base  <= 32'h8000_0000;
      free_start <= 32'h8000_0000;
      free_end   <= 32'h8040_0000;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_POOL_BASE:  pool_base  <= cfg_data;
        CFG_FREE_START: free_start <= cfg_data;
        CFG_FREE_END:   free_end   <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      ptr   <= '0;
    end else begin
      unique case (state)
        S_CLEAR: begin
          ptr <= ptr + WA_W'(1);
          if (ptr == LAST_WORD) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op  <= action;
            chk <= '0;
            ptr <= WA_W'(1);
            unique case (action)
              ACT_ALLOC: state <= S_ALLOC;
              ACT_FREE:  state <= S_FCHK;
              ACT_INIT:  state <= S_INIT;
              ACT_QUERY: state <= q_ok ? S_RMW : S_FIN;
              default:   state <= S_FIN;
            endcase
          end
        end
        S_ALLOC: begin
          if ((mem_q != '0) || (chk == LAST_WORD)) begin
            state <= S_FIN;
          end else begin
            chk <= chk + WA_W'(1);
            ptr <= ptr + WA_W'(1);
          end
        end
        S_FCHK: begin
          state <= f_ok ? S_RMW : S_FIN;
        end
        S_RMW: begin
          state <= S_FIN;
        end
        S_INIT: begin
          if (rng.done) begin
            state <= S_ISCAN;
          end
        end
        S_ISCAN: begin
          if (chk == LAST_WORD) begin
            state <= S_FIN;
          end else begin
            chk <= chk + WA_W'(1);
            ptr <= ptr + WA_W'(1);
          end
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Request context and pending result; payload only, no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_l     <= address;
      wsel       <= q_ext[WA_W+BIT_W-1:BIT_W];
      bsel       <= q_ext[BIT_W-1:0];
      res_addr   <= '0;
      res_free   <= 1'b0;
      res_status <= STAT_OK;
    end
    if (state == S_ALLOC) begin
      if (mem_q != '0) begin
        res_addr <= alloc_addr;
      end else if (chk == LAST_WORD) begin
        res_status <= STAT_OOM;
      end
    end
    if (state == S_FCHK) begin
      wsel <= f_k[WA_W+BIT_W-1:BIT_W];
      bsel <= f_k[BIT_W-1:0];
      if (!f_ok) begin
        res_status <= STAT_RANGE;
      end
    end
    if ((state == S_RMW) && (op == ACT_QUERY)) begin
      res_free <= mem_q[bsel];
    end
  end

  // Output register: loaded when the request finishes and the slot is free.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_FIN) && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_FIN) && out_free) begin
      page_address <= res_addr;
      page_free    <= res_free;
      status       <= res_status;
    end
  end

endmodule

`default_nettype wire

// ===== design/bpa_range.sv =====
`default_nettype none

module bpa_range import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [ADDR_W-1:0] pool_base,
  input  wire logic [ADDR_W-1:0] free_start,
  input  wire logic [ADDR_W-1:0] free_end,
  output range_t                 rng
);

  logic [AW-1:0] pb;
  logic [AW-1:0] fs;
  logic [AW-1:0] fe;
  logic [AW-1:0] rd;

  logic          v1;
  logic          v2;
  logic          v3;
  logic          v4;
  logic [AW-1:0] cs;
  logic [AW-1:0] ce;
  logic [AW-1:0] lo;
  logic [AW-1:0] hi;
  logic [AW-1:0] kraw;
  logic          set_ok;
  logic [AW-1:0] i0w;
  logic [AW-1:0] nw;
  logic [AW-1:0] i1w;
  logic [IW-1:0] kclr;
  logic [IW-1:0] i0c;
  logic [IW-1:0] i1c;

  assign pb  = AW'(pool_base);
  assign fs  = AW'(free_start);
  assign fe  = AW'(free_end);
  assign rd  = fs & ~PG_MASK_W;
  assign i1w = i0w + nw;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
    end else begin
      v1 <= start;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
    end
  end

  always_ff @(posedge clk) begin
    // Stage one: rounded bounds and the window of addresses that can hit the pool.
    if (start) begin
      cs     <= (fs + PG_MASK_W) & ~PG_MASK_W;
      ce     <= fe & ~PG_MASK_W;
      lo     <= (pb + PG_MASK_W) & ~PG_MASK_W;
      hi     <= pb + (AW'(PAGE_COUNT) << PAGE_SHIFT) + PG_MASK_W + AW'(1);
      set_ok <= free_start < free_end;
      kraw   <= (rd >= pb) ? ((rd - pb) >> PAGE_SHIFT) : '0;
    end
    // Stage two: clamp the walk to that window.
    if (v1) begin
      if (cs < lo) begin
        cs <= lo;
      end
      if (ce > hi) begin
        ce <= hi;
      end
      kclr <= (kraw > AW'(PAGE_COUNT)) ? IW'(PAGE_COUNT) : kraw[IW-1:0];
    end
    // Stage three: first page index and page count of the walk.
    if (v2) begin
      i0w <= (cs - pb) >> PAGE_SHIFT;
      nw  <= (set_ok && (cs < ce)) ? ((ce - cs) >> PAGE_SHIFT) : '0;
    end
    // Stage four: pages past the pool are dropped.
    if (v3) begin
      i0c <= (i0w > AW'(PAGE_COUNT)) ? IW'(PAGE_COUNT) : i0w[IW-1:0];
      i1c <= (i1w > AW'(PAGE_COUNT)) ? IW'(PAGE_COUNT) : i1w[IW-1:0];
    end
  end

  assign rng.done   = v4;
  assign rng.kclr   = kclr;
  assign rng.set_lo = i0c;
  assign rng.set_hi = i1c;

endmodule

`default_nettype wire

// ===== dv/bitmap_page_allocator_checker.sv =====
`default_nettype none

module bitmap_page_allocator_checker import bpa_pkg::*; (
  input  wire logic              clk,
  input  wire logic              rst,

  input  wire logic              in_valid,
  input  wire logic              in_ready,
  input  wire logic [1:0]        action,
  input  wire logic [ADDR_W-1:0] address,
  input  wire logic [9:0]        page_index,

  input  wire logic              out_valid,
  input  wire logic              out_ready,
  input  wire logic [ADDR_W-1:0] page_address,
  input  wire logic              page_free,
  input  wire logic [1:0]        status,

  input  wire logic              cfg_valid,
  input  wire logic              cfg_ready,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [ADDR_W-1:0] cfg_data,

  output int                     mismatch_count,
  output int                     expected_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [ADDR_W-1:0] POOL_BASE_RST  = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FREE_START_RST = 32'h8000_0000;
  localparam logic [ADDR_W-1:0] FREE_END_RST   = 32'h8040_0000;

  localparam logic [63:0] PAGE_BYTES  = 64'd1 << PAGE_SHIFT;
  localparam logic [63:0] OFFSET_BITS = PAGE_BYTES - 64'd1;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              page_free;
    logic [1:0]        status;
  } grant_t;

  // Shadow of the allocator: one free bit per page plus the three registers.
  bit                free_bits [PAGE_COUNT];
  logic [ADDR_W-1:0] base_q;
  logic [ADDR_W-1:0] start_q;
  logic [ADDR_W-1:0] end_q;
  grant_t            grants_due [$];

  function automatic logic [63:0] page_floor(input logic [63:0] a);
    return a & ~OFFSET_BITS;
  endfunction

  // Page index of an address, or 0 when it lands outside the pool.
  function automatic bit locate_page(input logic [63:0] a, output int unsigned idx);
    logic [63:0] r;
    logic [63:0] k;
    idx = 0;
    r = page_floor(a);
    if (r < 64'(base_q)) return 1'b0;
    k = (r - 64'(base_q)) >> PAGE_SHIFT;
    if (k >= 64'(PAGE_COUNT)) return 1'b0;
    idx = int'(k);
    return 1'b1;
  endfunction

  // Kernel pages below the free-start bound go occupied, then every whole
  // page in the rounded bounds that lies inside the pool goes free.
  function automatic void init_pages();
    logic [63:0] rd;
    logic [63:0] k;
    logic [63:0] cs;
    logic [63:0] ce;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] p;
    int unsigned idx;
    rd = page_floor(64'(start_q));
    if (rd >= 64'(base_q)) begin
      k = (rd - 64'(base_q)) >> PAGE_SHIFT;
      if (k > 64'(PAGE_COUNT)) k = 64'(PAGE_COUNT);
      for (int j = 0; j < int'(k); j++) free_bits[j] = 1'b0;
    end
    if (start_q >= end_q) return;
    cs = page_floor(64'(start_q) + OFFSET_BITS);
    ce = page_floor(64'(end_q));
    lo = page_floor(64'(base_q) + OFFSET_BITS);
    if (cs < lo) cs = lo;
    hi = 64'(base_q) + (64'(PAGE_COUNT) << PAGE_SHIFT) + PAGE_BYTES;
    if (ce > hi) ce = hi;
    for (p = cs; p < ce; p += PAGE_BYTES) begin
      if (locate_page(p, idx)) free_bits[idx] = 1'b1;
    end
  endfunction

  function automatic grant_t predict_grant(input logic [1:0] act,
                                           input logic [ADDR_W-1:0] addr,
                                           input logic [9:0] pidx);
    grant_t g;
    int unsigned idx;
    g = '0;
    case (act)
      ACT_ALLOC: begin
        g.status = STAT_OOM;
        for (int i = 0; i < PAGE_COUNT; i++) begin
          if (free_bits[i]) begin
            free_bits[i] = 1'b0;
            g.page_address = ADDR_W'(64'(base_q) + (64'(i) << PAGE_SHIFT));
            g.status = STAT_OK;
            break;
          end
        end
      end
      ACT_FREE: begin
        if (locate_page(64'(addr), idx)) free_bits[idx] = 1'b1;
        else g.status = STAT_RANGE;
      end
      ACT_INIT: begin
        init_pages();
      end
      ACT_QUERY: begin
        if (int'(pidx) < PAGE_COUNT) g.page_free = free_bits[pidx];
      end
    endcase
    return g;
  endfunction

  always @(posedge clk) begin
    grant_t want;
    if (rst) begin
      foreach (free_bits[i]) free_bits[i] = 1'b0;
      base_q = POOL_BASE_RST;
      start_q = FREE_START_RST;
      end_q = FREE_END_RST;
      grants_due.delete();
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_POOL_BASE:  base_q = cfg_data;
          CFG_FREE_START: start_q = cfg_data;
          CFG_FREE_END:   end_q = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && in_ready) grants_due.push_back(predict_grant(action, address, page_index));
      if (out_valid && out_ready) begin
        if (grants_due.size() == 0) begin
          $display("%0t: result word with none expected: page_address %h page_free %b status %0d",
                   $time, page_address, page_free, status);
          mismatch_count++;
        end else begin
          want = grants_due.pop_front();
          if (page_address !== want.page_address) begin
            $display("%0t: page_address expected %h actual %h",
                     $time, want.page_address, page_address);
            mismatch_count++;
          end
          if (page_free !== want.page_free) begin
            $display("%0t: page_free expected %b actual %b", $time, want.page_free, page_free);
            mismatch_count++;
          end
          if (status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, status);
            mismatch_count++;
          end
        end
      end
    end
    expected_count = grants_due.size();
  end

endmodule

`default_nettype wire

// ===== dv/bitmap_page_allocator_tb.sv =====
`default_nettype none

// Top of the page allocator bench. This module only makes stimulus and gives
// the verdict; the checker beside the block watches all three channels,
// keeps its own copy of the free map and the registers, and counts mismatches.
module bitmap_page_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bpa_pkg::*;

  localparam int TX_GAP_MAX     = 10;
  localparam int RX_STALL_MAX   = 10;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int PHASE_COUNT    = 12;
  localparam int FIXED_LAYOUTS  = 8;
  localparam int PHASE_ITEMS    = 140;
  localparam int DRAIN_CYCLES   = 40;
  localparam int RUN_LIMIT_NS   = 2_000_000;

  // Index 3 names no register; the block must shrug a write to it off.
  localparam logic [1:0] CFG_SPARE = 2'd3;

  logic              clk = 1'b0;
  logic              rst = 1'b1;

  logic              in_valid = 1'b0;
  wire logic         in_ready;
  logic [1:0]        action = ACT_QUERY;
  logic [ADDR_W-1:0] address = '0;
  logic [9:0]        page_index = '0;

  wire logic              out_valid;
  logic                   out_ready = 1'b0;
  wire logic [ADDR_W-1:0] page_address;
  wire logic              page_free;
  wire logic [1:0]        status;

  logic              cfg_valid = 1'b0;
  wire logic         cfg_ready;
  logic [1:0]        cfg_index = CFG_POOL_BASE;
  logic [ADDR_W-1:0] cfg_data = '0;

  int mismatch_count;
  int expected_count;

  // Idle shaping, changed by the stimulus from phase to phase.
  int                tx_gap_max = TX_GAP_MAX;
  int                rx_stall_max = RX_STALL_MAX;
  bit                rx_hold = 1'b0;
  logic [ADDR_W-1:0] pool_base_now = 32'h8000_0000;

  bitmap_page_allocator dut (.*);

  bitmap_page_allocator_checker checker_i (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Offers one request word after a random gap and holds it until the block
  // takes it. Every call begins and ends at a falling edge, and valid is only
  // ever driven there, so a back-to-back word keeps valid high at the edge.
  task automatic send_word(input logic [1:0] act, input logic [ADDR_W-1:0] addr,
                           input logic [9:0] pidx);
    int gap;
    gap = (tx_gap_max > 0) ? $urandom_range(0, tx_gap_max) : 0;
    repeat (gap) @(negedge clk);
    in_valid = 1'b1;
    action = act;
    address = addr;
    page_index = pidx;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [ADDR_W-1:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Holds the sender back until every predicted result word has come out.
  task automatic wait_idle();
    while (expected_count != 0) @(negedge clk);
  endtask

  // One random request. Most frees aim at a page of the current pool (the
  // two pages just past its end included) so that allocate and free keep
  // trading pages; the rest are arbitrary addresses, mostly out of range.
  task automatic random_word();
    int pick;
    int unsigned k;
    logic [ADDR_W-1:0] a;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      send_word(ACT_ALLOC, $urandom, 10'($urandom));
    end else if (pick < 68) begin
      k = $urandom_range(0, PAGE_COUNT + 1);
      a = pool_base_now + ADDR_W'(k << PAGE_SHIFT) + ($urandom & PG_MASK);
      send_word(ACT_FREE, a, 10'($urandom));
    end else if (pick < 75) begin
      send_word(ACT_FREE, $urandom, 10'($urandom));
    end else if (pick < 96) begin
      send_word(ACT_QUERY, $urandom, 10'($urandom));
    end else begin
      send_word(ACT_INIT, $urandom, 10'($urandom));
    end
  endtask

  // Result side: a random stall before each word, and a long hold-off when
  // the stimulus asks for one, counted here in cycles.
  initial begin
    int stall;
    wait (!rst);
    @(negedge clk);
    forever begin
      if (rx_hold) begin
        out_ready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk);
        rx_hold = 1'b0;
      end
      stall = (rx_stall_max > 0) ? $urandom_range(0, rx_stall_max) : 0;
      if (stall > 0) begin
        out_ready = 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1'b1;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    logic [ADDR_W-1:0] b;
    logic [ADDR_W-1:0] s;
    logic [ADDR_W-1:0] e;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed words under the reset layout: pool at 0x8000_0000, 1024 pages,
    // init bounds covering the whole pool. Right after reset every page is
    // occupied, so the first allocate must run out of memory.
    send_word(ACT_QUERY, '0, 10'h000);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_FREE, 32'h0000_0000, '0);   // below the pool
    send_word(ACT_FREE, 32'hFFFF_FFFF, '0);   // far past the pool
    send_word(ACT_FREE, 32'h8040_0000, '0);   // first page past the end
    send_word(ACT_FREE, 32'h7FFF_FFFF, '0);   // one byte below the pool
    send_word(ACT_FREE, 32'h8000_0FFF, '0);   // last byte of page 0
    send_word(ACT_FREE, 32'h803F_F000, '0);   // last page of the pool
    send_word(ACT_QUERY, '0, 10'h000);
    send_word(ACT_QUERY, '0, 10'h3FF);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_INIT, '0, '0);
    send_word(ACT_QUERY, '0, 10'h2AA);
    send_word(ACT_QUERY, '0, 10'h155);
    send_word(ACT_ALLOC, '0, '0);
    send_word(ACT_ALLOC, '0, '0);

    // Empty init range: equal bounds free nothing, yet the pages below the
    // start bound still go occupied while the pages above keep their bits.
    wait_idle();
    write_reg(CFG_FREE_START, 32'h8020_0000);
    write_reg(CFG_FREE_END, 32'h8020_0000);
    write_reg(CFG_SPARE, $urandom);
    send_word(ACT_INIT, '0, '0);
    send_word(ACT_QUERY, '0, 10'h000);
    send_word(ACT_QUERY, '0, 10'd600);
    send_word(ACT_ALLOC, '0, '0);

    // Random phases. The first layouts are picked by hand for the corner
    // cases: partial bounds that need rounding, an unaligned pool base, a
    // pool that wraps past the top of the address space, bounds at both
    // extremes and bounds reaching beyond both ends of the pool. The last
    // phases draw their layout at random. Each phase opens with an init.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin b = 32'h8000_0000; s = 32'h8000_0000; e = 32'h8040_0000; end
        1: begin b = 32'h8000_0000; s = 32'h8020_0123; e = 32'h8030_0FFF; end
        2: begin b = 32'h1000_0800; s = 32'h1000_0000; e = 32'h1050_0000; end
        3: begin b = 32'hFFF0_0000; s = 32'hFFF0_0000; e = 32'hFFFF_FFFF; end
        4: begin b = 32'h0000_0000; s = 32'h0000_0000; e = 32'hFFFF_FFFF; end
        5: begin b = 32'hFFFF_FFFF; s = 32'hFFFF_FFFF; e = 32'h0000_0000; end
        6: begin b = 32'h8000_0000; s = 32'h0000_0000; e = 32'hFFFF_FFFF; end
        7: begin b = 32'h4000_0000; s = 32'h4010_0000; e = 32'h4010_0000; end
        default: begin
          b = $urandom;
          if ($urandom_range(0, 1) == 0) b = b & ~PG_MASK;
          s = b + ADDR_W'($urandom_range(0, PAGE_COUNT + 8) << PAGE_SHIFT)
                + ($urandom & PG_MASK);
          e = s + ADDR_W'($urandom_range(0, PAGE_COUNT + 8) << PAGE_SHIFT)
                - ADDR_W'($urandom_range(0, 1 << PAGE_SHIFT));
        end
      endcase

      // Registers only change once the block has nothing left in flight.
      wait_idle();
      write_reg(CFG_POOL_BASE, b);
      write_reg(CFG_FREE_START, s);
      write_reg(CFG_FREE_END, e);
      pool_base_now = b;

      // Rotate through idling on both sides, on one side only, and none.
      case (ph % 4)
        0: begin tx_gap_max = TX_GAP_MAX; rx_stall_max = RX_STALL_MAX; end
        1: begin tx_gap_max = 0; rx_stall_max = RX_STALL_MAX; end
        2: begin tx_gap_max = TX_GAP_MAX; rx_stall_max = 0; end
        default: begin tx_gap_max = 0; rx_stall_max = 0; end
      endcase

      send_word(ACT_INIT, $urandom, 10'($urandom));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        // A long hold-off on the result side while words keep coming, so
        // the output register fills and the block backs up its input.
        if (ph == 1 && n == 40) rx_hold = 1'b1;
        // And once the sender stops until the block has drained completely.
        if (ph == 4 && n == 70) wait_idle();
        random_word();
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && expected_count == 0) begin
      $display("bitmap_page_allocator_tb: PASS");
    end else begin
      $display("bitmap_page_allocator_tb: FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #RUN_LIMIT_NS;
    $display("bitmap_page_allocator_tb: FAIL");
    $finish;
  end

endmodule

`default_nettype wire
